FILE: rtl/cddi_pkg.sv
// Shared constants, the per-track payload type and the decimal digit helper for the disc ID block.
`timescale 1ns / 1ps

package cddi_pkg;

	localparam int unsigned MaxTrackCount = 99;
	localparam logic [15:0] LeadInReset = 16'd150;

	// Frames per second of audio.
	localparam logic [19:0] FramesPerSec = 20'd75;

	// floor(x / 75) == (x * Recip75) >> 33 for every x below 2**26.
	localparam logic [26:0] Recip75 = 27'd114532462;
	localparam int unsigned Recip75Shift = 33;

	// floor(x / 1000) == (x * Recip1000) >> 30 for every x below 2**20.
	localparam logic [20:0] Recip1000 = 21'd1073742;
	localparam int unsigned Recip1000Shift = 30;

	localparam logic [8:0] IdModulus = 9'd255;

	// One track as it travels down the pipeline.
	typedef struct packed {
		logic [25:0] offset;
		logic [12:0] length;
		logic [6:0]  count;
		logic [19:0] total;
		logic        ovf;
		logic        last;
		logic        take;
	} trk_t;

	// Leading decimal digit of v, for v below ten times unit.
	function automatic logic [3:0] lead_digit(input logic [9:0] v, input logic [9:0] unit);
		logic [3:0] d;
		logic [9:0] thr;
		d = 4'd0;
		thr = unit;
		for (int k = 1; k < 10; k++) begin
			if (v >= thr) begin
				d = d + 4'd1;
			end
			thr = thr + unit;
		end
		return d;
	endfunction

endpackage

FILE: rtl/cd_disc_id_calc.sv
// Disc identifier calculator for a CD track-listing database, with its digit sum pipeline.
`timescale 1ns / 1ps

// Usage
// Track lengths (minutes, seconds) enter on the in_valid/in_ready channel in track order,
// one item per track, with is_last set on the final track of a disc. Each item yields one
// result item on out_valid/out_ready: the track's start frame, its length in seconds, the
// running track count and total seconds, the overflow flag and, on the last track, the
// finished 32-bit ID (digit sum mod 255, total seconds mod 65536, track count).
// The lead-in frame offset is written through cfg_valid/cfg_ready on lead_in_frames; the
// write is always taken and must only happen while no item is in flight.
// Throughput is one item per cycle while out_ready is high. The block is a seven-register
// pipeline: the running state is updated at the input, a multiply by the reciprocal of 75
// and one of 1000 split offset/75 into two three-digit halves, two stages of compares peel
// off the decimal digits, and the output register adds the digit sum into the running sum
// and forms the ID. Every stage has its own valid bit and loads whenever it is empty or its
// successor loads, so a stalled receiver holds the output register and each full stage
// behind it; the input keeps taking items until every stage is full, and no item is
// dropped or repeated.
// Reset empties the pipeline, clears all running sums and the track count, and sets the
// lead-in offset to 150 frames. The item marked last clears the running state for the next disc.
module cd_disc_id_calc #(
	parameter int unsigned MAX_TRACK_COUNT = cddi_pkg::MaxTrackCount
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] lead_in_frames,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [6:0]  track_minutes,
	input  logic [5:0]  track_secs,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [25:0] track_offset,
	output logic [12:0] track_length_secs,
	output logic [6:0]  track_count,
	output logic [19:0] total_secs,
	output logic [31:0] disc_id,
	output logic        done_res,
	output logic        overflow
);
	import cddi_pkg::*;

	// Running state of the current disc and the lead-in register.
	logic [15:0] lead_in_q;
	logic [25:0] frame_q;
	logic [19:0] secs_q;
	logic [6:0]  count_q;
	logic        ovf_q;
	logic [12:0] dsum_q;

	// Stage valid bits and load enables.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;
	logic in_acc;

	// Pipeline payload.
	trk_t        trk_s1, trk_s2, trk_s3, trk_s4, trk_s5, trk_s6;
	logic [19:0] q_s2, q_s3;
	logic [9:0]  hi_s3, hi_s4, lo_s4;
	logic [3:0]  dh_s5, dl_s5;
	logic [6:0]  rh_s5, rl_s5;
	logic [5:0]  ds_s6;

	// Output register.
	logic [25:0] off_s7;
	logic [12:0] len_s7;
	logic [6:0]  cnt_s7;
	logic [19:0] tot_s7;
	logic [31:0] id_s7;
	logic        last_s7;
	logic        ovf_s7;

	// Input stage arithmetic.
	logic [12:0] len_in;
	logic [19:0] len_x75;
	logic [25:0] off_in;
	logic [25:0] frame_nxt;
	logic [19:0] secs_nxt;
	logic [6:0]  count_nxt;
	logic        take_in;
	trk_t        trk_in;

	// Later stage arithmetic.
	logic [52:0] prod75;
	logic [40:0] prod1k;
	logic [19:0] lo_full;
	logic [3:0]  dh_nxt, dl_nxt, th_nxt, tl_nxt;
	logic [9:0]  rh_full, rl_full;
	logic [6:0]  oh_nxt, ol_nxt;
	logic [5:0]  ds_nxt;
	logic [12:0] dsum_nxt;
	logic [8:0]  fold;
	logic [8:0]  fold_mod;

	// Handshake: a stage loads when it is empty or its successor loads.
	assign cfg_ready = 1'b1;
	assign ld7 = !vld_s7 || out_ready;
	assign ld6 = !vld_s6 || ld7;
	assign ld5 = !vld_s5 || ld6;
	assign ld4 = !vld_s4 || ld5;
	assign ld3 = !vld_s3 || ld4;
	assign ld2 = !vld_s2 || ld3;
	assign ld1 = !vld_s1 || ld2;
	assign in_ready = ld1;
	assign in_acc = in_valid && in_ready;

	// The first track of a disc starts at the lead-in; later ones where the previous ended.
	always_comb begin
		len_in    = 13'({6'd0, track_minutes} * 13'd60) + 13'(track_secs);
		len_x75   = 20'(len_in) * FramesPerSec;
		take_in   = count_q < 7'(MAX_TRACK_COUNT);
		off_in    = (count_q == 7'd0) ? {10'd0, lead_in_q} : frame_q;
		frame_nxt = off_in + 26'(len_x75);
		secs_nxt  = secs_q + 20'(len_in);
		count_nxt = count_q + 7'd1;

		// A track beyond the limit is reported with zero offset and length.
		trk_in.offset = take_in ? off_in : 26'd0;
		trk_in.length = take_in ? len_in : 13'd0;
		trk_in.count  = take_in ? count_nxt : count_q;
		trk_in.total  = take_in ? secs_nxt : secs_q;
		trk_in.ovf    = take_in ? ovf_q : 1'b1;
		trk_in.last   = is_last;
		trk_in.take   = take_in;
	end

	// offset / 75 by reciprocal, then split into thousands and the three low digits.
	always_comb begin
		prod75  = 53'(trk_s1.offset) * 53'(Recip75);
		prod1k  = 41'(q_s2) * 41'(Recip1000);
		lo_full = q_s3 - 20'(hi_s3) * 20'd1000;
	end

	// Hundreds digit of each half by parallel compares, then tens and units.
	always_comb begin
		dh_nxt  = lead_digit(hi_s4, 10'd100);
		dl_nxt  = lead_digit(lo_s4, 10'd100);
		rh_full = hi_s4 - 10'(dh_nxt) * 10'd100;
		rl_full = lo_s4 - 10'(dl_nxt) * 10'd100;

		th_nxt = lead_digit({3'd0, rh_s5}, 10'd10);
		tl_nxt = lead_digit({3'd0, rl_s5}, 10'd10);
		oh_nxt = rh_s5 - 7'(th_nxt) * 7'd10;
		ol_nxt = rl_s5 - 7'(tl_nxt) * 7'd10;
		ds_nxt = 6'(dh_s5) + 6'(dl_s5) + 6'(th_nxt) + 6'(tl_nxt) + 6'(oh_nxt) + 6'(ol_nxt);
	end

	// Running digit sum and its residue mod 255; 256 is 1 mod 255, so fold the top bits.
	always_comb begin
		dsum_nxt = dsum_q + 13'(ds_s6);
		fold     = 9'(dsum_nxt[12:8]) + 9'(dsum_nxt[7:0]);
		fold_mod = (fold >= IdModulus) ? fold - IdModulus : fold;
	end

	// Control state: valid bits, running state and the lead-in register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			lead_in_q <= LeadInReset;
			frame_q   <= 26'd0;
			secs_q    <= 20'd0;
			count_q   <= 7'd0;
			ovf_q     <= 1'b0;
			dsum_q    <= 13'd0;
		end else begin
			if (ld1) vld_s1 <= in_valid;
			if (ld2) vld_s2 <= vld_s1;
			if (ld3) vld_s3 <= vld_s2;
			if (ld4) vld_s4 <= vld_s3;
			if (ld5) vld_s5 <= vld_s4;
			if (ld6) vld_s6 <= vld_s5;
			if (ld7) vld_s7 <= vld_s6;

			if (cfg_valid && cfg_ready) begin
				lead_in_q <= lead_in_frames;
			end

			// The last track closes the disc; everything restarts from zero.
			if (in_acc) begin
				priority if (is_last) begin
					frame_q <= 26'd0;
					secs_q  <= 20'd0;
					count_q <= 7'd0;
					ovf_q   <= 1'b0;
				end else if (take_in) begin
					frame_q <= frame_nxt;
					secs_q  <= secs_nxt;
					count_q <= count_nxt;
				end else begin
					ovf_q <= 1'b1;
				end
			end

			// The digit sum trails the other state by the pipeline depth, in item order.
			if (ld7 && vld_s6) begin
				dsum_q <= trk_s6.last ? 13'd0 : dsum_nxt;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (ld1) trk_s1 <= trk_in;
		if (ld2) begin
			trk_s2 <= trk_s1;
			q_s2   <= prod75[Recip75Shift +: 20];
		end
		if (ld3) begin
			trk_s3 <= trk_s2;
			q_s3   <= q_s2;
			hi_s3  <= prod1k[Recip1000Shift +: 10];
		end
		if (ld4) begin
			trk_s4 <= trk_s3;
			hi_s4  <= hi_s3;
			lo_s4  <= lo_full[9:0];
		end
		if (ld5) begin
			trk_s5 <= trk_s4;
			dh_s5  <= dh_nxt;
			dl_s5  <= dl_nxt;
			rh_s5  <= rh_full[6:0];
			rl_s5  <= rl_full[6:0];
		end
		if (ld6) begin
			trk_s6 <= trk_s5;
			ds_s6  <= trk_s5.take ? ds_nxt : 6'd0;
		end
		if (ld7) begin
			off_s7  <= trk_s6.offset;
			len_s7  <= trk_s6.length;
			cnt_s7  <= trk_s6.count;
			tot_s7  <= trk_s6.total;
			ovf_s7  <= trk_s6.ovf;
			last_s7 <= trk_s6.last;
			id_s7   <= trk_s6.last ? {fold_mod[7:0], trk_s6.total[15:0], {1'b0, trk_s6.count}}
				: 32'd0;
		end
	end

	assign out_valid         = vld_s7;
	assign track_offset      = off_s7;
	assign track_length_secs = len_s7;
	assign track_count       = cnt_s7;
	assign total_secs        = tot_s7;
	assign disc_id           = id_s7;
	assign done_res          = last_s7;
	assign overflow          = ovf_s7;

	// The ID carries the track count of the same result in its low byte.
	a_id_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> disc_id[7:0] == {1'b0, track_count})
		else $error("disc ID low byte differs from the track count");

	// Only the last track of a disc carries an ID.
	a_id_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> disc_id == 32'd0)
		else $error("disc ID present on a track that is not the last");

	// Once the limit is exceeded, the count sits at the limit and tracks are ignored.
	a_ovf_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> track_count == 7'(MAX_TRACK_COUNT) && track_length_secs == 13'd0)
		else $error("overflow reported with the track count below the limit");

	// A stalled output stage does not drop the item it holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && !out_ready |=> vld_s7 && $stable(id_s7))
		else $error("output stage lost its item while stalled");

endmodule
